// ----- hw/rtl/ptsv_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ptsv_pkg;

   // width of the running message length counter
   localparam int LENGTH_WIDTH = 20;
   // width of the widest configuration register
   localparam int CSR_DATA_WIDTH = 20;
   localparam int CSR_INDEX_WIDTH = 2;

   localparam logic [7:0] FORMAT_VERSION = 8'd2;
   localparam logic [7:0] PREFIX_LEN_LIMIT = 8'd32;

   typedef enum logic [3:0] {
      KIND_VERSION,
      KIND_COUNT,
      KIND_NODE,
      KIND_KEY,
      KIND_HOP_COUNT,
      KIND_HOP,
      KIND_FLAGS,
      KIND_PREFIX_COUNT,
      KIND_PREFIX,
      KIND_PREFIX_LEN,
      KIND_SURPLUS,
      KIND_IGNORED
   } field_kind_type;

   typedef enum logic [3:0] {
      ERR_NONE,
      ERR_SHORT,
      ERR_TOO_LONG,
      ERR_BAD_VERSION,
      ERR_TOO_MANY_PEERS,
      ERR_TOO_MANY_HOPS,
      ERR_FLAGS_SET,
      ERR_TOO_MANY_PREFIXES,
      ERR_PREFIX_LEN,
      ERR_TRUNCATED,
      ERR_TRAILING
   } error_type;

   typedef enum logic [1:0] {
      VERDICT_BUSY,
      VERDICT_ACCEPT,
      VERDICT_REJECT
   } verdict_type;

   typedef struct packed {
      logic [15:0]               max_peers;
      logic [7:0]                max_hops;
      logic [7:0]                max_prefixes;
      logic [CSR_DATA_WIDTH-1:0] max_message_bytes;
   } limits_type;

   typedef struct packed {
      field_kind_type field_kind;
      logic [4:0]     byte_in_field;
      logic [15:0]    peer_number;
      logic [7:0]     sub_number;
      verdict_type    verdict;
      error_type      error_code;
      logic           message_end;
   } result_type;

   // number of bytes in a field of the given kind
   function automatic logic [5:0] field_length(input field_kind_type kind);
      logic [5:0] len;
      case (kind)
         KIND_COUNT:  len = 6'd2;
         KIND_NODE:   len = 6'd32;
         KIND_KEY:    len = 6'd32;
         KIND_HOP:    len = 6'd32;
         KIND_PREFIX: len = 6'd4;
         default:     len = 6'd1;
      endcase
      return len;
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/peer_table_stream_validator.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Peer-table message checker. Bytes enter on the req_ channel, one item per
// byte with req_final_byte on the last, and every byte gives exactly one
// rsp_ item naming its field, its place in the field, the peer and hop or
// prefix index, and a running verdict; the verdict on the item carrying
// rsp_message_end is final, after which the checker is ready for the next
// message. One byte is taken every clock cycle unless rsp_stall holds the
// pipeline; a byte is held in an input register, then parsed into a result
// register whose outputs drive the rsp_ ports; rsp_stall holds both stages.
// Limits are set through the csr_ write port (0 max peers, 1 max hops, 2 max
// prefixes, 3 max message bytes); they are to be written only between
// messages by the user, and the block itself does not enforce this.
module peer_table_stream_validator
   import ptsv_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,

   input  wire logic                       csr_write_enable,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0]  csr_data,

   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic [7:0]                 req_data_byte,
   input  wire logic                       req_final_byte,

   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic [3:0]                      rsp_field_kind,
   output logic [4:0]                      rsp_byte_in_field,
   output logic [15:0]                     rsp_peer_number,
   output logic [7:0]                      rsp_sub_number,
   output logic [1:0]                      rsp_verdict,
   output logic [3:0]                      rsp_error_code,
   output logic                            rsp_message_end
);

   limits_type limits;
   result_type result;
   result_type result_ff;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_final_ff;
   logic       out_valid_ff, out_valid_in;
   logic       advance;
   logic       req_take;

   ptsv_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .limits           (limits)
   );

   ptsv_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .limits     (limits),
      .data_byte  (in_byte_ff),
      .final_byte (in_final_ff),
      .advance    (advance),
      .result     (result)
   );

   // pipeline flow: the held byte moves on when the result register is free
   assign advance = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // input and result payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_data_byte;
         in_final_ff <= req_final_byte;
      end
      if (advance) begin
         result_ff <= result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_field_kind = result_ff.field_kind;
   assign rsp_byte_in_field = result_ff.byte_in_field;
   assign rsp_peer_number = result_ff.peer_number;
   assign rsp_sub_number = result_ff.sub_number;
   assign rsp_verdict = result_ff.verdict;
   assign rsp_error_code = result_ff.error_code;
   assign rsp_message_end = result_ff.message_end;

endmodule

`default_nettype wire

// ----- hw/rtl/ptsv_csr.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ptsv_csr
   import ptsv_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_write_enable,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0]  csr_data,
   output limits_type                      limits
);

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_MAX_PEERS,
      CSR_MAX_HOPS,
      CSR_MAX_PREFIXES,
      CSR_MAX_MESSAGE_BYTES
   } csr_index_type;

   limits_type limits_ff;
   limits_type limits_in;

   // register write decode
   always_comb begin
      limits_in = limits_ff;
      if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_MAX_PEERS:         limits_in.max_peers = csr_data[15:0];
            CSR_MAX_HOPS:          limits_in.max_hops = csr_data[7:0];
            CSR_MAX_PREFIXES:      limits_in.max_prefixes = csr_data[7:0];
            CSR_MAX_MESSAGE_BYTES: limits_in.max_message_bytes = csr_data;
            default:               limits_in = limits_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limits_ff.max_peers <= 16'd256;
         limits_ff.max_hops <= 8'd8;
         limits_ff.max_prefixes <= 8'd16;
         limits_ff.max_message_bytes <= CSR_DATA_WIDTH'(65536);
      end else begin
         limits_ff <= limits_in;
      end
   end

   assign limits = limits_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/ptsv_parser.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ptsv_parser
   import ptsv_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  limits_type      limits,
   input  wire logic [7:0] data_byte,
   input  wire logic       final_byte,
   input  wire logic       advance,
   output result_type      result
);

   localparam int CMP_W =
      ((LENGTH_WIDTH > CSR_DATA_WIDTH) ? LENGTH_WIDTH : CSR_DATA_WIDTH) + 1;
   localparam logic [LENGTH_WIDTH-1:0] TOTAL_MAX = {LENGTH_WIDTH{1'b1}};

   field_kind_type          phase_ff, phase_in;
   logic [4:0]              fbc_ff, fbc_in;
   logic [15:0]             peers_left_ff, peers_left_in;
   logic [15:0]             peer_index_ff, peer_index_in;
   logic [7:0]              items_left_ff, items_left_in;
   logic [7:0]              item_index_ff, item_index_in;
   logic [7:0]              count_high_ff, count_high_in;
   logic [LENGTH_WIDTH-1:0] total_ff, total_in;
   error_type               err_latched_ff, err_latched_in;

   logic [5:0]       field_len;
   logic [4:0]       fbc_eff;
   logic             field_last;
   logic             too_long;
   logic [15:0]      peer_count;
   logic [15:0]      peers_dec;
   logic [7:0]       items_dec;
   error_type        err;
   result_type       res;

   // field position, wrapped if it ran past the field
   assign field_len = field_length(phase_ff);
   assign fbc_eff = ({1'b0, fbc_ff} >= field_len) ? 5'd0 : fbc_ff;
   assign field_last = (6'({1'b0, fbc_eff}) + 6'd1) >= field_len;

   // length limit check on the byte now arriving
   assign too_long = (CMP_W'(total_ff) + CMP_W'(1)) > CMP_W'(limits.max_message_bytes);

   assign peer_count = {count_high_ff, data_byte};
   assign peers_dec = peers_left_ff - 16'd1;
   assign items_dec = items_left_ff - 8'd1;

   // per-byte parse and state update
   always_comb begin
      phase_in = phase_ff;
      fbc_in = fbc_ff;
      peers_left_in = peers_left_ff;
      peer_index_in = peer_index_ff;
      items_left_in = items_left_ff;
      item_index_in = item_index_ff;
      count_high_in = count_high_ff;
      total_in = total_ff;
      err_latched_in = err_latched_ff;
      err = ERR_NONE;

      res = '0;
      res.message_end = final_byte;

      if (err_latched_ff != ERR_NONE) begin
         // absorb bytes until the end of the message
         res.field_kind = KIND_IGNORED;
         res.verdict = VERDICT_REJECT;
         res.error_code = err_latched_ff;
      end else begin
         res.field_kind = phase_ff;
         if (phase_ff != KIND_SURPLUS) begin
            res.byte_in_field = fbc_eff;
            if (phase_ff >= KIND_NODE) begin
               res.peer_number = peer_index_ff;
            end
            if (phase_ff == KIND_HOP || phase_ff == KIND_PREFIX ||
                phase_ff == KIND_PREFIX_LEN) begin
               res.sub_number = item_index_ff;
            end
         end

         if (total_ff != TOTAL_MAX) begin
            total_in = total_ff + LENGTH_WIDTH'(1);
         end

         if (too_long) begin
            err = ERR_TOO_LONG;
         end else if (phase_ff == KIND_SURPLUS) begin
            err = ERR_TRAILING;
         end else begin
            if (phase_ff == KIND_COUNT && fbc_eff == 5'd0) begin
               count_high_in = data_byte;
            end
            if (!field_last) begin
               fbc_in = fbc_eff + 5'd1;
            end else begin
               fbc_in = 5'd0;
               // last byte of a field: checks and phase step
               case (phase_ff)
                  KIND_VERSION: begin
                     if (data_byte != FORMAT_VERSION) begin
                        err = ERR_BAD_VERSION;
                     end else begin
                        phase_in = KIND_COUNT;
                     end
                  end
                  KIND_COUNT: begin
                     if (peer_count > limits.max_peers) begin
                        err = ERR_TOO_MANY_PEERS;
                     end else begin
                        peers_left_in = peer_count;
                        peer_index_in = 16'd0;
                        phase_in = (peer_count == 16'd0) ? KIND_SURPLUS : KIND_NODE;
                     end
                  end
                  KIND_NODE: phase_in = KIND_KEY;
                  KIND_KEY:  phase_in = KIND_HOP_COUNT;
                  KIND_HOP_COUNT: begin
                     if (data_byte > limits.max_hops) begin
                        err = ERR_TOO_MANY_HOPS;
                     end else begin
                        items_left_in = data_byte;
                        item_index_in = 8'd0;
                        phase_in = (data_byte == 8'd0) ? KIND_FLAGS : KIND_HOP;
                     end
                  end
                  KIND_HOP: begin
                     item_index_in = item_index_ff + 8'd1;
                     items_left_in = items_dec;
                     if (items_dec == 8'd0) begin
                        phase_in = KIND_FLAGS;
                     end
                  end
                  KIND_FLAGS: begin
                     if (data_byte != 8'd0) begin
                        err = ERR_FLAGS_SET;
                     end else begin
                        phase_in = KIND_PREFIX_COUNT;
                     end
                  end
                  KIND_PREFIX_COUNT: begin
                     if (data_byte > limits.max_prefixes) begin
                        err = ERR_TOO_MANY_PREFIXES;
                     end else begin
                        items_left_in = data_byte;
                        item_index_in = 8'd0;
                        if (data_byte == 8'd0) begin
                           peer_index_in = peer_index_ff + 16'd1;
                           peers_left_in = peers_dec;
                           phase_in = (peers_dec == 16'd0) ? KIND_SURPLUS : KIND_NODE;
                        end else begin
                           phase_in = KIND_PREFIX;
                        end
                     end
                  end
                  KIND_PREFIX: phase_in = KIND_PREFIX_LEN;
                  KIND_PREFIX_LEN: begin
                     if (data_byte > PREFIX_LEN_LIMIT) begin
                        err = ERR_PREFIX_LEN;
                     end else begin
                        item_index_in = item_index_ff + 8'd1;
                        items_left_in = items_dec;
                        if (items_dec == 8'd0) begin
                           peer_index_in = peer_index_ff + 16'd1;
                           peers_left_in = peers_dec;
                           phase_in = (peers_dec == 16'd0) ? KIND_SURPLUS : KIND_NODE;
                        end else begin
                           phase_in = KIND_PREFIX;
                        end
                     end
                  end
                  default: err = ERR_TRAILING;
               endcase
            end
         end

         // early end of the message
         if (err == ERR_NONE && final_byte && phase_in != KIND_SURPLUS) begin
            err = (phase_in == KIND_VERSION || phase_in == KIND_COUNT) ?
                  ERR_SHORT : ERR_TRUNCATED;
         end

         res.error_code = err;
         if (err != ERR_NONE) begin
            res.verdict = VERDICT_REJECT;
         end else if (final_byte) begin
            res.verdict = VERDICT_ACCEPT;
         end else begin
            res.verdict = VERDICT_BUSY;
         end
         err_latched_in = err;
      end

      // message end: back to the start state
      if (final_byte) begin
         phase_in = KIND_VERSION;
         fbc_in = 5'd0;
         peers_left_in = 16'd0;
         peer_index_in = 16'd0;
         items_left_in = 8'd0;
         item_index_in = 8'd0;
         count_high_in = 8'd0;
         total_in = '0;
         err_latched_in = ERR_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= KIND_VERSION;
         fbc_ff <= 5'd0;
         peers_left_ff <= 16'd0;
         peer_index_ff <= 16'd0;
         items_left_ff <= 8'd0;
         item_index_ff <= 8'd0;
         count_high_ff <= 8'd0;
         total_ff <= '0;
         err_latched_ff <= ERR_NONE;
      end else if (advance) begin
         phase_ff <= phase_in;
         fbc_ff <= fbc_in;
         peers_left_ff <= peers_left_in;
         peer_index_ff <= peer_index_in;
         items_left_ff <= items_left_in;
         item_index_ff <= item_index_in;
         count_high_ff <= count_high_in;
         total_ff <= total_in;
         err_latched_ff <= err_latched_in;
      end
   end

   assign result = res;

   // a latched error labels every byte as ignored
   a_ignored_after_error: assert property (@(posedge clock) disable iff (reset)
      err_latched_ff != ERR_NONE |-> res.field_kind == KIND_IGNORED)
      else $error("byte after error not marked ignored");

   // accept only on the final byte
   a_accept_on_final: assert property (@(posedge clock) disable iff (reset)
      res.verdict == VERDICT_ACCEPT |-> final_byte && res.error_code == ERR_NONE)
      else $error("accept verdict off the final byte");

   // rejection and error code go together
   a_reject_has_code: assert property (@(posedge clock) disable iff (reset)
      (res.verdict == VERDICT_REJECT) == (res.error_code != ERR_NONE))
      else $error("verdict and error code disagree");

   // final byte returns the parser to its start state
   a_clear_on_final: assert property (@(posedge clock) disable iff (reset)
      advance && final_byte |=>
         phase_ff == KIND_VERSION && total_ff == '0 && err_latched_ff == ERR_NONE)
      else $error("state not cleared after final byte");

endmodule

`default_nettype wire
